// ----- rtl/tpp_pkg.sv -----
package tpp_pkg;

	localparam int unsigned MaxWidth  = 256;
	localparam int unsigned MaxHeight = 256;

	localparam int unsigned ColW  = $clog2(MaxWidth);
	localparam int unsigned RowW  = $clog2(MaxHeight);
	localparam int unsigned DimW  = 9;
	localparam int unsigned PageW = 5;
	localparam int unsigned PixW  = 8;
	localparam int unsigned SumW  = 10;
	localparam int unsigned CfgW  = 9;
	localparam int unsigned IdxW  = 2;

	localparam logic [PixW-1:0] ThresholdReset = 8'd127;
	localparam logic [DimW-1:0] WidthReset     = 9'd128;
	localparam logic [DimW-1:0] HeightReset    = 9'd64;

	typedef enum logic [IdxW-1:0] {
		RegThreshold = 2'd0,
		RegWidth     = 2'd1,
		RegHeight    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic            en;
		logic [ColW-1:0] addr;
		logic [7:0]      data;
	} mem_wr_t;

endpackage

// ----- rtl/tpp_column_store.sv -----
module tpp_column_store
	import tpp_pkg::*;
(
	input  logic            clk,
	input  logic            rd_en,
	input  logic [ColW-1:0] rd_addr,
	input  mem_wr_t         wr,
	output logic [7:0]      rd_data_s1
);

	logic [7:0] mem [MaxWidth];

	// A read in the same cycle as a write to the same column returns the new byte.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_addr)) begin
				rd_data_s1 <= wr.data;
			end else begin
				rd_data_s1 <= mem[rd_addr];
			end
		end
	end

endmodule

// ----- rtl/threshold_page_packer_core.sv -----
// Packs a raster-order RGB pixel stream into page-format column bytes for a
// page-addressed monochrome display. The core takes one pixel per clock while
// in_stall is low and returns a byte through the stage-1 and output registers
// for every pixel of the eighth row of a page or of the last image row. The
// rate is set by the 256-entry column store, read when a pixel is taken and
// written when it leaves stage 1, with a bypass between the ports. The store
// is not cleared after reset: the first row of each page overwrites its
// entries. Change the threshold or image size only between frames.
module threshold_page_packer_core
	import tpp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_write,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]  cfg_data,

	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PixW-1:0]  pixel_red,
	input  logic [PixW-1:0]  pixel_green,
	input  logic [PixW-1:0]  pixel_blue,

	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       page_byte,
	output logic [ColW-1:0]  column_index,
	output logic [PageW-1:0] page_index,
	output logic             image_done
);

	logic [PixW-1:0] threshold_q;
	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;

	logic             valid_s1;
	logic             dark_s1;
	logic             emit_s1;
	logic             done_s1;
	logic [2:0]       bit_s1;
	logic [ColW-1:0]  col_s1;
	logic [PageW-1:0] page_s1;
	logic [7:0]       rd_data_s1;

	logic             valid_s2;
	logic [7:0]       byte_s2;
	logic [ColW-1:0]  col_s2;
	logic [PageW-1:0] page_s2;
	logic             done_s2;

	logic            accept;
	logic            fire_s1;
	logic [DimW-1:0] w_eff;
	logic [DimW-1:0] h_eff;
	logic [SumW-1:0] sum;
	logic [SumW-1:0] limit;
	logic            last_row;
	logic            last_col;
	logic [DimW-1:0] col_inc;
	logic [DimW-1:0] row_inc;
	logic [ColW-1:0] col_d;
	logic [RowW-1:0] row_d;
	logic [7:0]      byte_s1;
	mem_wr_t         wr;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DimW'(1);
		end else if (width_q > DimW'(MaxWidth)) begin
			w_eff = DimW'(MaxWidth);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DimW'(1);
		end else if (height_q > DimW'(MaxHeight)) begin
			h_eff = DimW'(MaxHeight);
		end else begin
			h_eff = height_q;
		end
	end

	// Stage 1 moves on unless it holds a byte and the output register is full and stalled.
	assign fire_s1  = valid_s1 && (!emit_s1 || !valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	assign sum   = SumW'(pixel_red) + SumW'(pixel_green) + SumW'(pixel_blue);
	assign limit = {1'b0, threshold_q, 1'b0} + SumW'(threshold_q);

	assign last_row = ({1'b0, row_q} == (h_eff - DimW'(1)));
	assign last_col = ({1'b0, col_q} == (w_eff - DimW'(1)));
	assign col_inc  = {1'b0, col_q} + DimW'(1);
	assign row_inc  = {1'b0, row_q} + DimW'(1);

	always_comb begin
		col_d = col_inc[ColW-1:0];
		row_d = row_q;
		if (col_inc >= w_eff) begin
			col_d = '0;
			row_d = (row_inc >= h_eff) ? '0 : row_inc[RowW-1:0];
		end
	end

	always_comb begin
		byte_s1 = (bit_s1 == 3'd0) ? 8'd0 : rd_data_s1;
		if (dark_s1) begin
			byte_s1[bit_s1] = 1'b1;
		end
	end

	assign wr.en   = fire_s1;
	assign wr.addr = col_s1;
	assign wr.data = byte_s1;

	tpp_column_store u_store (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr    (col_q),
		.wr         (wr),
		.rd_data_s1 (rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThresholdReset;
			width_q     <= WidthReset;
			height_q    <= HeightReset;
		end else if (cfg_write) begin
			unique case (cfg_index)
				RegThreshold: threshold_q <= cfg_data[PixW-1:0];
				RegWidth:     width_q     <= cfg_data;
				RegHeight:    height_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && emit_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dark_s1 <= (sum < limit);
			bit_s1  <= row_q[2:0];
			col_s1  <= col_q;
			page_s1 <= PageW'(row_q >> 3);
			emit_s1 <= (row_q[2:0] == 3'd7) || last_row;
			done_s1 <= last_row && last_col;
		end
		if (fire_s1 && emit_s1) begin
			byte_s2 <= byte_s1;
			col_s2  <= col_s1;
			page_s2 <= page_s1;
			done_s2 <= done_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign page_byte    = byte_s2;
	assign column_index = col_s2;
	assign page_index   = page_s2;
	assign image_done   = done_s2;

endmodule

// ----- tb/threshold_page_packer_core_tb.sv -----
`timescale 1ns / 1ps

module threshold_page_packer_core_tb;
	import tpp_pkg::*;

	localparam int CycleLimit  = 500_000;
	localparam int DrainCycles = 8;

	// Index 3 decodes to no register; a write there must change nothing.
	localparam logic [IdxW-1:0] RegSpare = 2'd3;

	typedef struct packed {
		logic [7:0]       bits;
		logic [ColW-1:0]  col;
		logic [PageW-1:0] page;
		logic             done;
	} page_beat_t;

	typedef enum bit {StepWrite, StepPixel} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [IdxW-1:0]  idx;
		logic [CfgW-1:0]  data;
		logic [PixW-1:0]  red;
		logic [PixW-1:0]  green;
		logic [PixW-1:0]  blue;
		bit               typed;
		page_beat_t       want;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [IdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]  cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [PixW-1:0]  pixel_red = '0;
	logic [PixW-1:0]  pixel_green = '0;
	logic [PixW-1:0]  pixel_blue = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       page_byte;
	logic [ColW-1:0]  column_index;
	logic [PageW-1:0] page_index;
	logic             image_done;

	// Shadow of the core: registers, line store and raster position.
	logic [PixW-1:0] cur_threshold = ThresholdReset;
	logic [DimW-1:0] cur_width = WidthReset;
	logic [DimW-1:0] cur_height = HeightReset;
	logic [7:0]      column_bytes [MaxWidth];
	int              pixel_col = 0;
	int              pixel_row = 0;

	page_beat_t expected_beats [$];
	plan_row_t  plan [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	threshold_page_packer_core u_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic int eff_dim(input int v, input int limit);
		return (v == 0) ? 1 : ((v > limit) ? limit : v);
	endfunction

	function automatic logic [7:0] clamp_chan(input int v);
		return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
	endfunction

	// Thresholds one pixel, folds it into its column byte and advances the
	// raster position. Returns 1 when the pixel completes a byte.
	function automatic bit pack_pixel(input logic [7:0] r, g, b, output page_beat_t beat);
		int w, h, sum, col, row, bitn;
		logic [7:0] acc;
		bit last_row;
		w = eff_dim(cur_width, MaxWidth);
		h = eff_dim(cur_height, MaxHeight);
		sum = int'(r) + int'(g) + int'(b);
		col = pixel_col % MaxWidth;
		row = pixel_row;
		bitn = row % 8;
		acc = (bitn == 0) ? 8'h00 : column_bytes[col];
		if (sum < 3 * int'(cur_threshold))
			acc[bitn] = 1'b1;
		column_bytes[col] = acc;
		last_row = (row == h - 1);
		beat.bits = acc;
		beat.col = col[ColW-1:0];
		beat.page = row[PageW+2:3];
		beat.done = last_row && (col == w - 1);
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h)
				row = 0;
		end
		pixel_col = col;
		pixel_row = row % MaxHeight;
		return (bitn == 7) || last_row;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		page_beat_t want;
		if (arst_n && out_valid !== 1'b0 && out_stall == 1'b0) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: beat expected none, got byte %0h col %0h page %0h done %0b",
					$time, page_byte, column_index, page_index, image_done);
				mismatch_count++;
			end else begin
				want = expected_beats.pop_front();
				compare_field("page_byte", want.bits, page_byte);
				compare_field("column_index", want.col, column_index);
				compare_field("page_index", 8'(want.page), 8'(page_index));
				compare_field("image_done", 8'(want.done), 8'(image_done));
			end
		end
	end

	// Holds the pixel port idle until every outstanding byte has come back.
	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
		wait_drained(DrainCycles);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			RegThreshold: cur_threshold = data[PixW-1:0];
			RegWidth:     cur_width = data;
			RegHeight:    cur_height = data;
			default:      ;
		endcase
	endtask

	task automatic feed_pixel(input logic [7:0] r, g, b, input bit typed,
			input page_beat_t want);
		int gap;
		page_beat_t beat;
		bit emitted;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_red <= r;
		pixel_green <= g;
		pixel_blue <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		emitted = pack_pixel(r, g, b, beat);
		if (emitted)
			expected_beats.push_back(typed ? want : beat);
	endtask

	function automatic void add_write(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
		plan_row_t row;
		row = '{kind: StepWrite, idx: idx, data: data, red: '0, green: '0, blue: '0,
			typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	function automatic void add_pixel(input logic [7:0] r, g, b);
		plan_row_t row;
		row = '{kind: StepPixel, idx: '0, data: '0, red: r, green: g, blue: b,
			typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	// In a one-pixel image every beat is column 0, page 0 and ends the image.
	function automatic void add_check(input logic [7:0] r, g, b, input logic [7:0] bits);
		plan_row_t row;
		row = '{kind: StepPixel, idx: '0, data: '0, red: r, green: g, blue: b,
			typed: 1'b1, want: '{bits: bits, col: '0, page: '0, done: 1'b1}};
		plan.push_back(row);
	endfunction

	// Whole frames with fresh settings between them, so the line store is
	// always rewritten at the top of each page before it is read.
	task automatic run_frames(input int quota, input logic [CfgW-1:0] first_w, first_h);
		int sent, pick, npix, target;
		logic [CfgW-1:0] w, h;
		logic [7:0] r, g, b;
		page_beat_t none;
		sent = 0;
		w = first_w;
		h = first_h;
		none = '0;
		while (sent < quota) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				write_reg(RegThreshold, '0);
			else if (pick == 1)
				write_reg(RegThreshold, 9'd255);
			else if (pick == 2)
				write_reg(RegThreshold, CfgW'($urandom_range(256, 511)));
			else if (pick < 10)
				write_reg(RegThreshold, CfgW'($urandom_range(0, 255)));
			write_reg(RegWidth, w);
			write_reg(RegHeight, h);
			npix = eff_dim(w, MaxWidth) * eff_dim(h, MaxHeight);
			repeat (npix) begin
				pick = $urandom_range(0, 3);
				if (pick == 1) begin
					// Land the channel sum right around three times the threshold.
					target = 3 * int'(cur_threshold) + int'($urandom_range(0, 4)) - 2;
					r = clamp_chan(target / 3 + int'($urandom_range(0, 16)) - 8);
					g = clamp_chan(target / 3 + int'($urandom_range(0, 16)) - 8);
					b = clamp_chan(target - int'(r) - int'(g));
				end else if (pick == 2) begin
					r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end else begin
					r = 8'($urandom);
					g = 8'($urandom);
					b = 8'($urandom);
				end
				feed_pixel(r, g, b, 1'b0, none);
				sent++;
				if ($urandom_range(0, 199) == 0)
					wait_drained(0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				w = $urandom_range(0, 1) ? 9'd256 : CfgW'($urandom_range(257, 511));
				h = CfgW'($urandom_range(0, 1));
			end else if (pick < 6) begin
				w = CfgW'($urandom_range(0, 1));
				h = $urandom_range(0, 1) ? 9'd256 : CfgW'($urandom_range(257, 511));
			end else begin
				w = CfgW'($urandom_range(0, 10));
				h = CfgW'($urandom_range(0, 18));
			end
		end
	endtask

	initial begin
		// Single-pixel images first: reset threshold on either side of the edge.
		add_write(RegWidth, 9'd1);
		add_write(RegHeight, 9'd1);
		add_check(8'd127, 8'd127, 8'd126, 8'h01);
		add_check(8'd127, 8'd127, 8'd127, 8'h00);
		add_write(RegSpare, 9'h1FF);
		add_check(8'd127, 8'd127, 8'd126, 8'h01);
		add_write(RegThreshold, 9'd0);
		add_check(8'd0, 8'd0, 8'd0, 8'h00);
		add_write(RegThreshold, 9'd255);
		add_check(8'd255, 8'd255, 8'd254, 8'h01);
		add_check(8'd255, 8'd255, 8'd255, 8'h00);
		// Zero width and height behave as one.
		add_write(RegWidth, 9'd0);
		add_write(RegHeight, 9'd0);
		add_check(8'd0, 8'd0, 8'd0, 8'h01);
		// Shrink the width in the middle of the first row of a page, leaving the
		// column counter past the new width.
		add_write(RegThreshold, 9'd100);
		add_write(RegWidth, 9'd8);
		add_write(RegHeight, 9'd2);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd10, 8'd20, 8'd30);
		add_pixel(8'd200, 8'd0, 8'd99);
		add_pixel(8'd99, 8'd101, 8'd100);
		add_write(RegWidth, 9'd3);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd99, 8'd100, 8'd100);
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd33, 8'd66, 8'd99);
		// Shrink the height below the current row: that row must not emit.
		add_write(RegWidth, 9'd1);
		add_write(RegHeight, 9'd4);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_write(RegHeight, 9'd2);
		add_pixel(8'd0, 8'd50, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd128, 8'd128, 8'd128);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 7;
		recv_stall_pct = 79;
		foreach (plan[i]) begin
			if (plan[i].kind == StepWrite)
				write_reg(plan[i].idx, plan[i].data);
			else
				feed_pixel(plan[i].red, plan[i].green, plan[i].blue, plan[i].typed,
					plan[i].want);
		end
		run_frames(340, 9'd511, 9'd1);

		send_idle_pct = 79;
		recv_stall_pct = 7;
		run_frames(340, 9'd1, 9'd256);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_frames(340, 9'd256, 9'd0);

		wait_drained(DrainCycles);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tpp_pkg.sv
rtl/tpp_column_store.sv
rtl/threshold_page_packer_core.sv
tb/threshold_page_packer_core_tb.sv
